>>> rtl/qte_pkg.sv
package qte_pkg;

	localparam int OP_W  = 34;
	localparam int XY_W  = 38;
	localparam int ACC_W = 26;
	localparam int SQ_W  = 63;
	localparam int SQRT_STEPS = 32;
	localparam int TAB_LEN = 30;

	localparam logic signed [ACC_W-1:0] ANG_90 = 26'sd5898240;
	localparam logic [30:0] LOCK_RESET = 31'd1073741717;
	localparam logic signed [16:0] LIM_180 = 17'sd23040;
	localparam logic signed [16:0] LIM_90 = 17'sd11520;

	typedef struct packed {
		logic                   valid;
		logic [SQ_W-1:0]        n;
		logic [SQ_W-1:0]        root;
		logic signed [31:0]     s;
		logic signed [OP_W-1:0] yn;
		logic signed [OP_W-1:0] yd;
		logic signed [OP_W-1:0] zn;
		logic signed [OP_W-1:0] zd;
		logic                   locked;
		logic                   pos;
	} sq_word_t;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ACC_W-1:0] acc;
		logic                    zero;
	} lane_t;

	typedef struct packed {
		logic       valid;
		lane_t [2:0] lane;
		logic       locked;
		logic       pos;
	} cw_word_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest
	function automatic logic signed [ACC_W-1:0] atan_tab(input int i);
		logic signed [ACC_W-1:0] r;
		unique case (i)
			0: r = 26'sd2949120;
			1: r = 26'sd1740967;
			2: r = 26'sd919879;
			3: r = 26'sd466945;
			4: r = 26'sd234379;
			5: r = 26'sd117304;
			6: r = 26'sd58666;
			7: r = 26'sd29335;
			8: r = 26'sd14668;
			9: r = 26'sd7334;
			10: r = 26'sd3667;
			11: r = 26'sd1833;
			12: r = 26'sd917;
			13: r = 26'sd458;
			14: r = 26'sd229;
			15: r = 26'sd115;
			16: r = 26'sd57;
			17: r = 26'sd29;
			18: r = 26'sd14;
			19: r = 26'sd7;
			20: r = 26'sd4;
			21: r = 26'sd2;
			22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [16:0] sat17(input logic signed [16:0] v,
		input logic signed [16:0] lim);
		logic signed [16:0] r;
		if (v > lim) r = lim;
		else if (v < -lim) r = -lim;
		else r = v;
		return r;
	endfunction

endpackage

>>> rtl/quaternion_to_euler.sv
// channel | signals                                           | direction
// quat    | quat_valid quat_stall quat_x/y/z/w                | into block
// angle   | angle_valid angle_stall angle_x/y/z gimbal_locked | out of block
// cfg     | cfg_we cfg_data (lock threshold)                  | into block
// One word per cycle unless angle_stall holds the chain; 38 + CORDIC_STEPS register
// stages, among them the 32-cell square-root chain and a CORDIC_STEPS-cell CORDIC
// chain that it feeds.
// Reset clears all valid bits and loads the lock threshold reset value.
// The whole chain holds while a result waits under angle_stall.
module quaternion_to_euler #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_data,
	input  logic               quat_valid,
	output logic               quat_stall,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               angle_valid,
	input  logic               angle_stall,
	output logic signed [14:0] angle_x,
	output logic signed [15:0] angle_y,
	output logic signed [15:0] angle_z,
	output logic               gimbal_locked
);
	import qte_pkg::*;

	localparam logic signed [OP_W-1:0] ONE = OP_W'(1) <<< 30;

	logic en;
	logic [30:0] thr_q;

	logic valid_s1, valid_s2, valid_s3;
	logic signed [31:0] wx_s1, yz_s1, xz_s1, wy_s1, xx_s1, yy_s1, xy_s1, wz_s1, zz_s1;
	logic signed [OP_W-1:0] sinx_s2, yn_u_s2, yd_u_s2, zn_s2, zd_s2, yn_l_s2, yd_l_s2;
	logic signed [31:0] s_s3;
	logic signed [OP_W-1:0] yn_s3, yd_s3, zn_s3, zd_s3;
	logic locked_s3, pos_s3;

	sq_word_t sq [0:SQRT_STEPS];
	cw_word_t cw [0:CORDIC_STEPS];

	logic out_valid_q;

	assign en = !(out_valid_q && angle_stall);
	assign quat_stall = !en;
	assign angle_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= LOCK_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// s1: component products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= quat_valid;
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xz_s1 <= quat_x * quat_z;
			wy_s1 <= quat_w * quat_y;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			xy_s1 <= quat_x * quat_y;
			wz_s1 <= quat_w * quat_z;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// s2: matrix terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			sinx_s2 <= (OP_W'(wx_s1) - OP_W'(yz_s1)) <<< 1;
			yn_u_s2 <= (OP_W'(xz_s1) + OP_W'(wy_s1)) <<< 1;
			yd_u_s2 <= ONE - ((OP_W'(xx_s1) + OP_W'(yy_s1)) <<< 1);
			zn_s2 <= (OP_W'(xy_s1) + OP_W'(wz_s1)) <<< 1;
			zd_s2 <= ONE - ((OP_W'(xx_s1) + OP_W'(zz_s1)) <<< 1);
			yn_l_s2 <= (OP_W'(wy_s1) - OP_W'(xz_s1)) <<< 1;
			yd_l_s2 <= ONE - ((OP_W'(yy_s1) + OP_W'(zz_s1)) <<< 1);
		end
	end

	// s3: lock decision and operand select
	logic [32:0] mag;
	logic lock_c;
	logic signed [31:0] s_c;

	always_comb begin
		mag = 33'(sinx_s2 < 0 ? -sinx_s2 : sinx_s2);
		lock_c = mag >= 33'(thr_q);
		if (sinx_s2 > ONE) s_c = 32'(ONE);
		else if (sinx_s2 < -ONE) s_c = -32'(ONE);
		else s_c = 32'(sinx_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			s_s3 <= s_c;
			locked_s3 <= lock_c;
			pos_s3 <= sinx_s2 > 0;
			yn_s3 <= lock_c ? yn_l_s2 : yn_u_s2;
			yd_s3 <= lock_c ? yd_l_s2 : yd_u_s2;
			// zero operands drive the z angle to zero when locked
			zn_s3 <= lock_c ? '0 : zn_s2;
			zd_s3 <= lock_c ? '0 : zd_s2;
		end
	end

	// s4: radicand 2^60 - s^2
	logic signed [63:0] ssq;
	assign ssq = s_s3 * s_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq[0].valid <= 1'b0;
		end else if (en) begin
			sq[0].valid <= valid_s3;
			sq[0].n <= SQ_W'((64'(1) << 60) - 64'(ssq));
			sq[0].root <= '0;
			sq[0].s <= s_s3;
			sq[0].yn <= yn_s3;
			sq[0].yd <= yd_s3;
			sq[0].zn <= zn_s3;
			sq[0].zd <= zd_s3;
			sq[0].locked <= locked_s3;
			sq[0].pos <= pos_s3;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		qte_sqrt_cell #(.K(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(sq[k]), .q(sq[k + 1])
		);
	end

	// pre-rotation into the right half plane
	function automatic lane_t prerot(input logic signed [OP_W-1:0] yv,
		input logic signed [OP_W-1:0] xv);
		lane_t l;
		l.zero = (yv == 0) && (xv == 0);
		if (xv < 0) begin
			if (yv >= 0) begin
				l.x = XY_W'(yv);
				l.y = -XY_W'(xv);
				l.acc = ANG_90;
			end else begin
				l.x = -XY_W'(yv);
				l.y = XY_W'(xv);
				l.acc = -ANG_90;
			end
		end else begin
			l.x = XY_W'(xv);
			l.y = XY_W'(yv);
			l.acc = '0;
		end
		return l;
	endfunction

	sq_word_t sq_end;
	assign sq_end = sq[SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw[0].valid <= 1'b0;
		end else if (en) begin
			cw[0].valid <= sq_end.valid;
			cw[0].lane[0] <= prerot(OP_W'(sq_end.s), OP_W'({1'b0, sq_end.root[30:0]}));
			cw[0].lane[1] <= prerot(sq_end.yn, sq_end.yd);
			cw[0].lane[2] <= prerot(sq_end.zn, sq_end.zd);
			cw[0].locked <= sq_end.locked;
			cw[0].pos <= sq_end.pos;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		qte_cordic_cell #(.I(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(cw[i]), .q(cw[i + 1])
		);
	end

	function automatic logic signed [16:0] reduce(input lane_t l);
		logic signed [ACC_W-1:0] t;
		logic signed [16:0] r;
		t = (l.acc + ACC_W'(256)) >>> 9;
		r = l.zero ? 17'sd0 : sat17(17'(t), LIM_180);
		return r;
	endfunction

	cw_word_t cw_end;
	logic signed [16:0] ax_c, ay_c, az_c;

	always_comb begin
		cw_end = cw[CORDIC_STEPS];
		ay_c = reduce(cw_end.lane[1]);
		az_c = reduce(cw_end.lane[2]);
		if (cw_end.locked) ax_c = cw_end.pos ? LIM_90 : -LIM_90;
		else ax_c = sat17(reduce(cw_end.lane[0]), LIM_90);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cw_end.valid;
			angle_x <= 15'(ax_c);
			angle_y <= 16'(ay_c);
			angle_z <= 16'(az_c);
			gimbal_locked <= cw_end.locked;
		end
	end

endmodule

>>> rtl/qte_sqrt_cell.sv
module qte_sqrt_cell #(
	parameter int K = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  qte_pkg::sq_word_t d,
	output qte_pkg::sq_word_t q
);
	import qte_pkg::*;

	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * K);

	sq_word_t nxt;
	logic [SQ_W-1:0] trial;

	always_comb begin
		nxt = d;
		trial = d.root + BIT;
		if (d.n >= trial) begin
			nxt.n = d.n - trial;
			nxt.root = (d.root >> 1) + BIT;
		end else begin
			nxt.root = d.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> rtl/qte_cordic_cell.sv
module qte_cordic_cell #(
	parameter int I = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  qte_pkg::cw_word_t d,
	output qte_pkg::cw_word_t q
);
	import qte_pkg::*;

	localparam logic signed [ACC_W-1:0] ANG = atan_tab(I);

	cw_word_t nxt;

	always_comb begin
		nxt = d;
		for (int j = 0; j < 3; j++) begin
			// rotate toward the x axis; a zero y counts as negative
			if (d.lane[j].y > 0) begin
				nxt.lane[j].x = d.lane[j].x + (d.lane[j].y >>> I);
				nxt.lane[j].y = d.lane[j].y - (d.lane[j].x >>> I);
				nxt.lane[j].acc = d.lane[j].acc + ANG;
			end else begin
				nxt.lane[j].x = d.lane[j].x - (d.lane[j].y >>> I);
				nxt.lane[j].y = d.lane[j].y + (d.lane[j].x >>> I);
				nxt.lane[j].acc = d.lane[j].acc - ANG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> rtl/qte_checker.sv
module qte_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               quat_stall,
	input logic               angle_valid,
	input logic               angle_stall,
	input logic signed [14:0] angle_x,
	input logic signed [15:0] angle_z,
	input logic               gimbal_locked
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && angle_stall |=> angle_valid)
		else $error("result word dropped under stall");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		quat_stall == (angle_valid && angle_stall))
		else $error("input stall does not follow output backpressure");

	a_lock_z: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && gimbal_locked |-> angle_z == 16'sd0)
		else $error("z angle nonzero while locked");

	a_lock_x: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && gimbal_locked |-> angle_x == 15'sd11520 || angle_x == -15'sd11520)
		else $error("x angle not pinned while locked");

	a_range_x: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> angle_x <= 15'sd11520 && angle_x >= -15'sd11520)
		else $error("x angle out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (
	.clk(clk), .arst_n(arst_n), .quat_stall(quat_stall),
	.angle_valid(angle_valid), .angle_stall(angle_stall), .angle_x(angle_x),
	.angle_z(angle_z), .gimbal_locked(gimbal_locked)
);
